// File: rtl/rwhp_pkg.sv
// Shared types and constants for the RIFF/WAVE header parser.
// Chunk identifiers, status codes, state encodings and divider interface.
// No dependencies.
package rwhp_pkg;

	// four-character codes, big-endian as read from the file
	localparam logic [31:0] ID_RIFF = 32'h5249_4646;
	localparam logic [31:0] ID_WAVE = 32'h5741_5645;
	localparam logic [31:0] ID_FORM = 32'h464F_524D;
	localparam logic [31:0] ID_AIFF = 32'h4149_4646;
	localparam logic [31:0] ID_AIFC = 32'h4149_4643;
	localparam logic [31:0] ID_DATA = 32'h6461_7461;
	localparam logic [31:0] ID_FMT  = 32'h666D_7420;
	localparam logic [31:0] ID_FACT = 32'h6661_6374;
	localparam logic [31:0] ID_ID3L = 32'h6964_3320;
	localparam logic [31:0] ID_ID3U = 32'h4944_3320;
	localparam logic [31:0] ID_ID32 = 32'h4944_3332;

	// result status codes
	localparam logic [2:0] ST_WAV_OK   = 3'd0;
	localparam logic [2:0] ST_AIFF_OK  = 3'd1;
	localparam logic [2:0] ST_SHORT    = 3'd2;
	localparam logic [2:0] ST_NO_RIFF  = 3'd3;
	localparam logic [2:0] ST_NO_WAVE  = 3'd4;
	localparam logic [2:0] ST_NO_AIFF  = 3'd5;

	// duration scale factors
	localparam logic [12:0] DATA_SCALE = 13'd8000;
	localparam logic [9:0]  FACT_SCALE = 10'd1000;

	// header length and dividend width (33-bit size times 8000)
	localparam logic [31:0] HDR_LEN = 32'd12;
	localparam int DVD_W = 46;

	// parse phase, one-hot
	typedef enum logic [4:0] {
		PH_HEAD = 5'b00001,
		PH_CHDR = 5'b00010,
		PH_LOAD = 5'b00100,
		PH_SKIP = 5'b01000,
		PH_IDLE = 5'b10000
	} phase_t;

	// block sequencer, one-hot
	typedef enum logic [2:0] {
		SQ_RUN = 3'b001,
		SQ_DIV = 3'b010,
		SQ_FIN = 3'b100
	} seq_t;

	// divider request and response
	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [31:0]      divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

endpackage

// File: rtl/riff_wave_header_parser_unit.sv
// RIFF/WAVE header parser and chunk walker, top level.
// Depends on rwhp_pkg and rwhp_divider.
//
// Usage: set file_length through cfg_write_en/cfg_write_data while idle, then
// stream the file one byte per transfer on in_valid/in_ready (data_byte,
// last_byte). The transfer carrying last_byte=1 produces one result on
// out_valid/out_ready; earlier bytes produce none.
// Throughput: one byte per cycle while in_ready is high. A data chunk header
// (with a known bit rate) or a four-byte fact chunk starts a duration
// division in the shared divider; in_ready stays low while it runs, one
// quotient bit per cycle. After the last byte the sequencer enters its finish
// state and the result moves into the output register once that is free
// (after the division if that byte started one); in_ready is low meanwhile.
// The next file may stream while a result waits in the output register; once
// its own result is ready, in_ready stays low until the waiting one is taken,
// so a stalled receiver holds off the input from then on.
// Reset clears all parse state and file_length; after each result the parse
// state returns to its reset values and file_length is kept.
module riff_wave_header_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [31:0] cfg_write_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic        stopped_early,
	output logic        data_found,
	output logic [15:0] channel_count,
	output logic [31:0] sample_rate,
	output logic [31:0] bit_rate,
	output logic [15:0] frame_align,
	output logic [15:0] sample_bits,
	output logic [31:0] pcm_offset,
	output logic [31:0] pcm_size,
	output logic [31:0] play_msec
);

	rwhp_pkg::seq_t   seq_q;
	rwhp_pkg::phase_t phase_q, n_phase;
	logic [31:0] file_len_q;
	logic        last_q;
	logic [4:0]  idx_q, n_idx;
	logic [31:0] fs_q, n_fs;
	logic [31:0] walk_q, n_walk;
	logic [31:0] cid_q, n_cid;
	logic [32:0] size_q, n_size;
	logic [32:0] skip_q, n_skip;
	logic [15:0] ch_q, n_ch;
	logic [31:0] sr_q, n_sr;
	logic [31:0] br_q, n_br;
	logic [15:0] ba_q, n_ba;
	logic [15:0] sb_q, n_sb;
	logic [31:0] aoff_q, n_aoff;
	logic [31:0] asize_q, n_asize;
	logic [31:0] dur_q;
	logic        fstop_q, n_fstop;
	logic        fdata_q, n_fdata;
	logic [2:0]  kstat_q, n_kstat;

	rwhp_pkg::div_req_t div_req;
	rwhp_pkg::div_rsp_t div_rsp;

	logic        in_xfer;
	logic        fin_go;
	logic [31:0] hdr_fs;
	logic [32:0] padded;
	logic [31:0] walk8;
	logic [32:0] remaining;
	logic [31:0] fin_end;
	logic        fin_stop;

	rwhp_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_ready = (seq_q == rwhp_pkg::SQ_RUN);
	assign in_xfer  = in_valid && in_ready;
	// result leaves the sequencer once the output register is free
	assign fin_go   = (seq_q == rwhp_pkg::SQ_FIN) && (!out_valid || out_ready);

	// per-byte parse step
	always_comb begin
		n_phase = phase_q;
		n_idx   = idx_q;
		n_fs    = fs_q;
		n_walk  = walk_q;
		n_cid   = cid_q;
		n_size  = size_q;
		n_skip  = skip_q;
		n_ch    = ch_q;
		n_sr    = sr_q;
		n_br    = br_q;
		n_ba    = ba_q;
		n_sb    = sb_q;
		n_aoff  = aoff_q;
		n_asize = asize_q;
		n_fstop = fstop_q;
		n_fdata = fdata_q;
		n_kstat = kstat_q;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = '0;
		hdr_fs    = '0;
		padded    = '0;
		walk8     = '0;
		remaining = '0;

		unique case (phase_q)
			rwhp_pkg::PH_HEAD: begin
				n_fs = {fs_q[23:0], data_byte};
				if (idx_q == 5'd3) n_cid = n_fs;
				if (idx_q == 5'd11) begin
					n_phase = rwhp_pkg::PH_IDLE;
					if (cid_q == rwhp_pkg::ID_RIFF) begin
						if (n_fs == rwhp_pkg::ID_WAVE) begin
							n_kstat = rwhp_pkg::ST_WAV_OK;
							n_walk  = rwhp_pkg::HDR_LEN;
							n_idx   = '0;
							n_fs    = '0;
							n_phase = ({1'b0, rwhp_pkg::HDR_LEN} + 33'd8 < {1'b0, file_len_q})
								? rwhp_pkg::PH_CHDR : rwhp_pkg::PH_IDLE;
						end else begin
							n_kstat = rwhp_pkg::ST_NO_WAVE;
						end
					end else if (cid_q == rwhp_pkg::ID_FORM) begin
						n_kstat = (n_fs == rwhp_pkg::ID_AIFF || n_fs == rwhp_pkg::ID_AIFC)
							? rwhp_pkg::ST_AIFF_OK : rwhp_pkg::ST_NO_AIFF;
					end else begin
						n_kstat = rwhp_pkg::ST_NO_RIFF;
					end
				end else begin
					if (idx_q == 5'd7) n_fs = '0;
					n_idx = idx_q + 5'd1;
				end
			end
			rwhp_pkg::PH_CHDR: begin
				if (idx_q < 5'd4) begin
					n_fs = {fs_q[23:0], data_byte};
					if (idx_q == 5'd3) begin
						n_cid = n_fs;
						n_fs  = '0;
					end
				end else begin
					n_fs = {data_byte, fs_q[31:8]};
				end
				hdr_fs = n_fs;
				if (idx_q == 5'd7) begin
					// chunk header complete
					padded    = {1'b0, hdr_fs} + {32'd0, hdr_fs[0]};
					walk8     = walk_q + 32'd8;
					remaining = (file_len_q > walk8) ? {1'b0, file_len_q - walk8} : 33'd0;
					n_walk    = walk8;
					n_size    = padded;
					n_idx     = '0;
					n_fs      = '0;
					if (cid_q == rwhp_pkg::ID_DATA) begin
						n_fdata = 1'b1;
						n_aoff  = walk8;
						n_asize = padded[31:0];
						if (dur_q == '0 && br_q != '0) begin
							div_req.start    = 1'b1;
							div_req.dividend = {13'd0, padded} * {33'd0, rwhp_pkg::DATA_SCALE};
							div_req.divisor  = br_q;
						end
					end
					if (cid_q != rwhp_pkg::ID_ID3L && cid_q != rwhp_pkg::ID_ID3U &&
					    cid_q != rwhp_pkg::ID_ID32 && padded > remaining) begin
						n_fstop = 1'b1;
						n_phase = rwhp_pkg::PH_IDLE;
					end else begin
						n_skip = padded;
						n_phase = (cid_q == rwhp_pkg::ID_DATA || cid_q == rwhp_pkg::ID_ID3L ||
						           cid_q == rwhp_pkg::ID_ID3U || cid_q == rwhp_pkg::ID_ID32)
							? rwhp_pkg::PH_SKIP : rwhp_pkg::PH_LOAD;
						if (padded == '0) begin
							n_phase = ({1'b0, walk8} + 33'd8 < {1'b0, file_len_q})
								? rwhp_pkg::PH_CHDR : rwhp_pkg::PH_IDLE;
						end
					end
				end else begin
					n_idx = idx_q + 5'd1;
				end
			end
			rwhp_pkg::PH_LOAD, rwhp_pkg::PH_SKIP: begin
				if (phase_q == rwhp_pkg::PH_LOAD) begin
					n_fs = {data_byte, fs_q[31:8]};
					if (cid_q == rwhp_pkg::ID_FMT) begin
						if (idx_q == 5'd3)  n_ch = n_fs[31:16];
						if (idx_q == 5'd7)  n_sr = n_fs;
						if (idx_q == 5'd11) n_br = {n_fs[28:0], 3'b000};
						if (idx_q == 5'd13) n_ba = n_fs[31:16];
						if (idx_q == 5'd15) n_sb = n_fs[31:16];
					end else if (cid_q == rwhp_pkg::ID_FACT && size_q == 33'd4 &&
					             idx_q == 5'd3 && sr_q != '0) begin
						div_req.start    = 1'b1;
						div_req.dividend = {14'd0, n_fs} * {36'd0, rwhp_pkg::FACT_SCALE};
						div_req.divisor  = sr_q;
					end
					if (idx_q < 5'd31) n_idx = idx_q + 5'd1;
				end
				if (skip_q != '0) n_skip = skip_q - 33'd1;
				if (n_skip == '0) begin
					n_walk  = walk_q + size_q[31:0];
					n_idx   = '0;
					n_fs    = '0;
					n_phase = ({1'b0, n_walk} + 33'd8 < {1'b0, file_len_q})
						? rwhp_pkg::PH_CHDR : rwhp_pkg::PH_IDLE;
				end
			end
			default: begin
			end
		endcase

		// only start the divider on an accepted byte
		div_req.start = div_req.start && in_xfer;
	end

	// end-of-file stop condition; the skip end wraps at 32 bits
	always_comb begin
		fin_end  = walk_q + size_q[31:0];
		fin_stop = fstop_q || phase_q == rwhp_pkg::PH_CHDR || phase_q == rwhp_pkg::PH_LOAD ||
			(phase_q == rwhp_pkg::PH_SKIP &&
			 ({1'b0, fin_end} + 33'd8 < {1'b0, file_len_q}));
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_len_q <= '0;
		end else if (cfg_write_en) begin
			file_len_q <= cfg_write_data;
		end
	end

	// sequencer and parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q   <= rwhp_pkg::SQ_RUN;
			last_q  <= 1'b0;
			phase_q <= rwhp_pkg::PH_HEAD;
			idx_q   <= '0;
			fs_q    <= '0;
			walk_q  <= rwhp_pkg::HDR_LEN;
			cid_q   <= '0;
			size_q  <= '0;
			skip_q  <= '0;
			ch_q    <= '0;
			sr_q    <= '0;
			br_q    <= '0;
			ba_q    <= '0;
			sb_q    <= '0;
			aoff_q  <= '0;
			asize_q <= '0;
			dur_q   <= '0;
			fstop_q <= 1'b0;
			fdata_q <= 1'b0;
			kstat_q <= '0;
		end else begin
			unique case (seq_q)
				rwhp_pkg::SQ_RUN: begin
					if (in_xfer) begin
						phase_q <= n_phase;
						idx_q   <= n_idx;
						fs_q    <= n_fs;
						walk_q  <= n_walk;
						cid_q   <= n_cid;
						size_q  <= n_size;
						skip_q  <= n_skip;
						ch_q    <= n_ch;
						sr_q    <= n_sr;
						br_q    <= n_br;
						ba_q    <= n_ba;
						sb_q    <= n_sb;
						aoff_q  <= n_aoff;
						asize_q <= n_asize;
						fstop_q <= n_fstop;
						fdata_q <= n_fdata;
						kstat_q <= n_kstat;
						last_q  <= last_byte;
						if (div_req.start) begin
							seq_q <= rwhp_pkg::SQ_DIV;
						end else if (last_byte) begin
							seq_q <= rwhp_pkg::SQ_FIN;
						end
					end
				end
				rwhp_pkg::SQ_DIV: begin
					if (div_rsp.done) begin
						dur_q <= div_rsp.quotient;
						seq_q <= last_q ? rwhp_pkg::SQ_FIN : rwhp_pkg::SQ_RUN;
					end
				end
				rwhp_pkg::SQ_FIN: begin
					// result captured below; return parse state to reset values
					if (fin_go) begin
						seq_q   <= rwhp_pkg::SQ_RUN;
						last_q  <= 1'b0;
						phase_q <= rwhp_pkg::PH_HEAD;
						idx_q   <= '0;
						fs_q    <= '0;
						walk_q  <= rwhp_pkg::HDR_LEN;
						cid_q   <= '0;
						size_q  <= '0;
						skip_q  <= '0;
						ch_q    <= '0;
						sr_q    <= '0;
						br_q    <= '0;
						ba_q    <= '0;
						sb_q    <= '0;
						aoff_q  <= '0;
						asize_q <= '0;
						dur_q   <= '0;
						fstop_q <= 1'b0;
						fdata_q <= 1'b0;
						kstat_q <= '0;
					end
				end
				default: begin
					seq_q <= rwhp_pkg::SQ_RUN;
				end
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fin_go) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			status        <= (phase_q == rwhp_pkg::PH_HEAD) ? rwhp_pkg::ST_SHORT : kstat_q;
			stopped_early <= fin_stop;
			data_found    <= fdata_q;
			channel_count <= ch_q;
			sample_rate   <= sr_q;
			bit_rate      <= br_q;
			frame_align   <= ba_q;
			sample_bits   <= sb_q;
			pcm_offset    <= aoff_q;
			pcm_size      <= asize_q;
			play_msec     <= dur_q;
		end
	end

endmodule

// File: rtl/rwhp_divider.sv
// Iterative restoring divider, one quotient bit per cycle, saturating to 32 bits.
// Uses rwhp_pkg for the request/response structs.
module rwhp_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  rwhp_pkg::div_req_t req,
	output rwhp_pkg::div_rsp_t rsp
);

	localparam int CNT_W = $clog2(rwhp_pkg::DVD_W + 1);

	logic [rwhp_pkg::DVD_W-1:0] quo_q;
	logic [31:0]                rem_q;
	logic [31:0]                dvs_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [32:0]                rem_sh;
	logic [32:0]                rem_dif;
	logic                       fits;

	// one shift-subtract step; the remainder stays below the divisor
	always_comb begin
		rem_sh  = {rem_q, quo_q[rwhp_pkg::DVD_W-1]};
		rem_dif = rem_sh - {1'b0, dvs_q};
		fits    = rem_sh >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				quo_q  <= req.dividend;
				dvs_q  <= req.divisor;
				rem_q  <= '0;
				cnt_q  <= CNT_W'(rwhp_pkg::DVD_W);
			end else if (busy_q) begin
				rem_q <= fits ? rem_dif[31:0] : rem_sh[31:0];
				quo_q <= {quo_q[rwhp_pkg::DVD_W-2:0], fits};
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// saturate quotient
	always_comb begin
		rsp.busy     = busy_q;
		rsp.done     = done_q;
		rsp.quotient = (quo_q[rwhp_pkg::DVD_W-1:32] != '0) ? 32'hFFFF_FFFF : quo_q[31:0];
	end

endmodule
